// ----- sv/sbo_pkg.sv -----
// ----------------------------------------------------------------------------
// sbo_pkg: shared types, constants and S-box tables
// Round count, byte tables and single-round functions.
// ----------------------------------------------------------------------------
package sbo_pkg;

  localparam int unsigned Rounds = 8;
  localparam int unsigned BlockW = 32;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [7:0]        byte_t;

  function automatic byte_t fwd_box(input byte_t a);
    byte_t r;
    unique case (a)
      8'h00: r=8'h63; 8'h01: r=8'h10; 8'h02: r=8'h6f; 8'h03: r=8'hcc;
      8'h04: r=8'h70; 8'h05: r=8'h2b; 8'h06: r=8'hfc; 8'h07: r=8'h40;
      8'h08: r=8'hda; 8'h09: r=8'h5b; 8'h0a: r=8'h31; 8'h0b: r=8'haf;
      8'h0c: r=8'h54; 8'h0d: r=8'hc0; 8'h0e: r=8'hdd; 8'h0f: r=8'hfa;
      8'h10: r=8'h16; 8'h11: r=8'hbf; 8'h12: r=8'h8f; 8'h13: r=8'h1c;
      8'h14: r=8'h61; 8'h15: r=8'hf9; 8'h16: r=8'h77; 8'h17: r=8'hf6;
      8'h18: r=8'h85; 8'h19: r=8'h5a; 8'h1a: r=8'h4c; 8'h1b: r=8'h1b;
      8'h1c: r=8'h30; 8'h1d: r=8'h27; 8'h1e: r=8'h01; 8'h1f: r=8'h4e;
      8'h20: r=8'h9d; 8'h21: r=8'h71; 8'h22: r=8'hf3; 8'h23: r=8'h6d;
      8'h24: r=8'h7a; 8'h25: r=8'h15; 8'h26: r=8'h73; 8'h27: r=8'h60;
      8'h28: r=8'h92; 8'h29: r=8'hce; 8'h2a: r=8'h37; 8'h2b: r=8'h72;
      8'h2c: r=8'h32; 8'h2d: r=8'h35; 8'h2e: r=8'hea; 8'h2f: r=8'ha3;
      8'h30: r=8'h84; 8'h31: r=8'h68; 8'h32: r=8'h3f; 8'h33: r=8'h55;
      8'h34: r=8'h0a; 8'h35: r=8'h0b; 8'h36: r=8'h24; 8'h37: r=8'he0;
      8'h38: r=8'h4f; 8'h39: r=8'h5f; 8'h3a: r=8'h69; 8'h3b: r=8'h67;
      8'h3c: r=8'h59; 8'h3d: r=8'h8e; 8'h3e: r=8'hf1; 8'h3f: r=8'h21;
      8'h40: r=8'hf5; 8'h41: r=8'h49; 8'h42: r=8'he5; 8'h43: r=8'h4d;
      8'h44: r=8'h80; 8'h45: r=8'ha6; 8'h46: r=8'h6a; 8'h47: r=8'h0f;
      8'h48: r=8'hf7; 8'h49: r=8'h8c; 8'h4a: r=8'hc1; 8'h4b: r=8'hc6;
      8'h4c: r=8'ha0; 8'h4d: r=8'h08; 8'h4e: r=8'hab; 8'h4f: r=8'hd3;
      8'h50: r=8'h05; 8'h51: r=8'hf4; 8'h52: r=8'h3a; 8'h53: r=8'h9a;
      8'h54: r=8'h91; 8'h55: r=8'h0d; 8'h56: r=8'h4b; 8'h57: r=8'hd0;
      8'h58: r=8'h6e; 8'h59: r=8'h79; 8'h5a: r=8'h07; 8'h5b: r=8'hd2;
      8'h5c: r=8'h87; 8'h5d: r=8'h11; 8'h5e: r=8'hf0; 8'h5f: r=8'h1a;
      8'h60: r=8'hc7; 8'h61: r=8'hb7; 8'h62: r=8'h03; 8'h63: r=8'h39;
      8'h64: r=8'h1d; 8'h65: r=8'h53; 8'h66: r=8'h28; 8'h67: r=8'hbd;
      8'h68: r=8'hec; 8'h69: r=8'hb8; 8'h6a: r=8'hfe; 8'h6b: r=8'h04;
      8'h6c: r=8'h9c; 8'h6d: r=8'h7e; 8'h6e: r=8'h62; 8'h6f: r=8'h06;
      8'h70: r=8'hd5; 8'h71: r=8'he4; 8'h72: r=8'h7c; 8'h73: r=8'hfb;
      8'h74: r=8'h74; 8'h75: r=8'h9f; 8'h76: r=8'hca; 8'h77: r=8'h18;
      8'h78: r=8'hff; 8'h79: r=8'hb2; 8'h7a: r=8'h0c; 8'h7b: r=8'ha1;
      8'h7c: r=8'h86; 8'h7d: r=8'h36; 8'h7e: r=8'hc8; 8'h7f: r=8'h9e;
      8'h80: r=8'hb0; 8'h81: r=8'h9b; 8'h82: r=8'h2e; 8'h83: r=8'h33;
      8'h84: r=8'h48; 8'h85: r=8'h09; 8'h86: r=8'hdf; 8'h87: r=8'hef;
      8'h88: r=8'h23; 8'h89: r=8'h3d; 8'h8a: r=8'hc9; 8'h8b: r=8'ha4;
      8'h8c: r=8'h56; 8'h8d: r=8'hb5; 8'h8e: r=8'h8b; 8'h8f: r=8'ha2;
      8'h90: r=8'h3c; 8'h91: r=8'h76; 8'h92: r=8'h82; 8'h93: r=8'hb3;
      8'h94: r=8'h2a; 8'h95: r=8'h26; 8'h96: r=8'h83; 8'h97: r=8'h98;
      8'h98: r=8'h64; 8'h99: r=8'h81; 8'h9a: r=8'hbe; 8'h9b: r=8'he6;
      8'h9c: r=8'h38; 8'h9d: r=8'he1; 8'h9e: r=8'hf8; 8'h9f: r=8'h58;
      8'ha0: r=8'hb4; 8'ha1: r=8'hd1; 8'ha2: r=8'hc2; 8'ha3: r=8'h96;
      8'ha4: r=8'hdb; 8'ha5: r=8'h93; 8'ha6: r=8'h19; 8'ha7: r=8'hac;
      8'ha8: r=8'h52; 8'ha9: r=8'hae; 8'haa: r=8'h0e; 8'hab: r=8'he3;
      8'hac: r=8'ha8; 8'had: r=8'h51; 8'hae: r=8'h88; 8'haf: r=8'hd6;
      8'hb0: r=8'heb; 8'hb1: r=8'h22; 8'hb2: r=8'h20; 8'hb3: r=8'h8d;
      8'hb4: r=8'h1e; 8'hb5: r=8'h2d; 8'hb6: r=8'h3e; 8'hb7: r=8'h43;
      8'hb8: r=8'hc3; 8'hb9: r=8'h78; 8'hba: r=8'h45; 8'hbb: r=8'ha7;
      8'hbc: r=8'hde; 8'hbd: r=8'h57; 8'hbe: r=8'h44; 8'hbf: r=8'hbb;
      8'hc0: r=8'h13; 8'hc1: r=8'ha9; 8'hc2: r=8'h94; 8'hc3: r=8'h14;
      8'hc4: r=8'h7f; 8'hc5: r=8'h25; 8'hc6: r=8'h7b; 8'hc7: r=8'h5d;
      8'hc8: r=8'h42; 8'hc9: r=8'h34; 8'hca: r=8'hee; 8'hcb: r=8'h97;
      8'hcc: r=8'hb9; 8'hcd: r=8'h29; 8'hce: r=8'hed; 8'hcf: r=8'h2f;
      8'hd0: r=8'hd9; 8'hd1: r=8'had; 8'hd2: r=8'hfd; 8'hd3: r=8'he9;
      8'hd4: r=8'hc5; 8'hd5: r=8'hd4; 8'hd6: r=8'h99; 8'hd7: r=8'hbc;
      8'hd8: r=8'he8; 8'hd9: r=8'hc4; 8'hda: r=8'hd7; 8'hdb: r=8'hcd;
      8'hdc: r=8'hd8; 8'hdd: r=8'hdc; 8'hde: r=8'hf2; 8'hdf: r=8'h02;
      8'he0: r=8'h89; 8'he1: r=8'h90; 8'he2: r=8'h50; 8'he3: r=8'h1f;
      8'he4: r=8'h41; 8'he5: r=8'hb1; 8'he6: r=8'hba; 8'he7: r=8'h8a;
      8'he8: r=8'h95; 8'he9: r=8'hb6; 8'hea: r=8'he2; 8'heb: r=8'hcb;
      8'hec: r=8'ha5; 8'hed: r=8'h6b; 8'hee: r=8'h6c; 8'hef: r=8'h46;
      8'hf0: r=8'h5c; 8'hf1: r=8'h65; 8'hf2: r=8'h75; 8'hf3: r=8'h2c;
      8'hf4: r=8'h5e; 8'hf5: r=8'h3b; 8'hf6: r=8'h7d; 8'hf7: r=8'h12;
      8'hf8: r=8'haa; 8'hf9: r=8'h17; 8'hfa: r=8'hcf; 8'hfb: r=8'h47;
      8'hfc: r=8'he7; 8'hfd: r=8'h4a; 8'hfe: r=8'h00; 8'hff: r=8'h66;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic byte_t inv_box(input byte_t a);
    byte_t r;
    unique case (a)
      8'h00: r=8'hfe; 8'h01: r=8'h1e; 8'h02: r=8'hdf; 8'h03: r=8'h62;
      8'h04: r=8'h6b; 8'h05: r=8'h50; 8'h06: r=8'h6f; 8'h07: r=8'h5a;
      8'h08: r=8'h4d; 8'h09: r=8'h85; 8'h0a: r=8'h34; 8'h0b: r=8'h35;
      8'h0c: r=8'h7a; 8'h0d: r=8'h55; 8'h0e: r=8'haa; 8'h0f: r=8'h47;
      8'h10: r=8'h01; 8'h11: r=8'h5d; 8'h12: r=8'hf7; 8'h13: r=8'hc0;
      8'h14: r=8'hc3; 8'h15: r=8'h25; 8'h16: r=8'h10; 8'h17: r=8'hf9;
      8'h18: r=8'h77; 8'h19: r=8'ha6; 8'h1a: r=8'h5f; 8'h1b: r=8'h1b;
      8'h1c: r=8'h13; 8'h1d: r=8'h64; 8'h1e: r=8'hb4; 8'h1f: r=8'he3;
      8'h20: r=8'hb2; 8'h21: r=8'h3f; 8'h22: r=8'hb1; 8'h23: r=8'h88;
      8'h24: r=8'h36; 8'h25: r=8'hc5; 8'h26: r=8'h95; 8'h27: r=8'h1d;
      8'h28: r=8'h66; 8'h29: r=8'hcd; 8'h2a: r=8'h94; 8'h2b: r=8'h05;
      8'h2c: r=8'hf3; 8'h2d: r=8'hb5; 8'h2e: r=8'h82; 8'h2f: r=8'hcf;
      8'h30: r=8'h1c; 8'h31: r=8'h0a; 8'h32: r=8'h2c; 8'h33: r=8'h83;
      8'h34: r=8'hc9; 8'h35: r=8'h2d; 8'h36: r=8'h7d; 8'h37: r=8'h2a;
      8'h38: r=8'h9c; 8'h39: r=8'h63; 8'h3a: r=8'h52; 8'h3b: r=8'hf5;
      8'h3c: r=8'h90; 8'h3d: r=8'h89; 8'h3e: r=8'hb6; 8'h3f: r=8'h32;
      8'h40: r=8'h07; 8'h41: r=8'he4; 8'h42: r=8'hc8; 8'h43: r=8'hb7;
      8'h44: r=8'hbe; 8'h45: r=8'hba; 8'h46: r=8'hef; 8'h47: r=8'hfb;
      8'h48: r=8'h84; 8'h49: r=8'h41; 8'h4a: r=8'hfd; 8'h4b: r=8'h56;
      8'h4c: r=8'h1a; 8'h4d: r=8'h43; 8'h4e: r=8'h1f; 8'h4f: r=8'h38;
      8'h50: r=8'he2; 8'h51: r=8'had; 8'h52: r=8'ha8; 8'h53: r=8'h65;
      8'h54: r=8'h0c; 8'h55: r=8'h33; 8'h56: r=8'h8c; 8'h57: r=8'hbd;
      8'h58: r=8'h9f; 8'h59: r=8'h3c; 8'h5a: r=8'h19; 8'h5b: r=8'h09;
      8'h5c: r=8'hf0; 8'h5d: r=8'hc7; 8'h5e: r=8'hf4; 8'h5f: r=8'h39;
      8'h60: r=8'h27; 8'h61: r=8'h14; 8'h62: r=8'h6e; 8'h63: r=8'h00;
      8'h64: r=8'h98; 8'h65: r=8'hf1; 8'h66: r=8'hff; 8'h67: r=8'h3b;
      8'h68: r=8'h31; 8'h69: r=8'h3a; 8'h6a: r=8'h46; 8'h6b: r=8'hed;
      8'h6c: r=8'hee; 8'h6d: r=8'h23; 8'h6e: r=8'h58; 8'h6f: r=8'h02;
      8'h70: r=8'h04; 8'h71: r=8'h21; 8'h72: r=8'h2b; 8'h73: r=8'h26;
      8'h74: r=8'h74; 8'h75: r=8'hf2; 8'h76: r=8'h91; 8'h77: r=8'h16;
      8'h78: r=8'hb9; 8'h79: r=8'h59; 8'h7a: r=8'h24; 8'h7b: r=8'hc6;
      8'h7c: r=8'h72; 8'h7d: r=8'hf6; 8'h7e: r=8'h6d; 8'h7f: r=8'hc4;
      8'h80: r=8'h44; 8'h81: r=8'h99; 8'h82: r=8'h92; 8'h83: r=8'h96;
      8'h84: r=8'h30; 8'h85: r=8'h18; 8'h86: r=8'h7c; 8'h87: r=8'h5c;
      8'h88: r=8'hae; 8'h89: r=8'he0; 8'h8a: r=8'he7; 8'h8b: r=8'h8e;
      8'h8c: r=8'h49; 8'h8d: r=8'hb3; 8'h8e: r=8'h3d; 8'h8f: r=8'h12;
      8'h90: r=8'he1; 8'h91: r=8'h54; 8'h92: r=8'h28; 8'h93: r=8'ha5;
      8'h94: r=8'hc2; 8'h95: r=8'he8; 8'h96: r=8'ha3; 8'h97: r=8'hcb;
      8'h98: r=8'h97; 8'h99: r=8'hd6; 8'h9a: r=8'h53; 8'h9b: r=8'h81;
      8'h9c: r=8'h6c; 8'h9d: r=8'h20; 8'h9e: r=8'h7f; 8'h9f: r=8'h75;
      8'ha0: r=8'h4c; 8'ha1: r=8'h7b; 8'ha2: r=8'h8f; 8'ha3: r=8'h2f;
      8'ha4: r=8'h8b; 8'ha5: r=8'hec; 8'ha6: r=8'h45; 8'ha7: r=8'hbb;
      8'ha8: r=8'hac; 8'ha9: r=8'hc1; 8'haa: r=8'hf8; 8'hab: r=8'h4e;
      8'hac: r=8'ha7; 8'had: r=8'hd1; 8'hae: r=8'ha9; 8'haf: r=8'h0b;
      8'hb0: r=8'h80; 8'hb1: r=8'he5; 8'hb2: r=8'h79; 8'hb3: r=8'h93;
      8'hb4: r=8'ha0; 8'hb5: r=8'h8d; 8'hb6: r=8'he9; 8'hb7: r=8'h61;
      8'hb8: r=8'h69; 8'hb9: r=8'hcc; 8'hba: r=8'he6; 8'hbb: r=8'hbf;
      8'hbc: r=8'hd7; 8'hbd: r=8'h67; 8'hbe: r=8'h9a; 8'hbf: r=8'h11;
      8'hc0: r=8'h0d; 8'hc1: r=8'h4a; 8'hc2: r=8'ha2; 8'hc3: r=8'hb8;
      8'hc4: r=8'hd9; 8'hc5: r=8'hd4; 8'hc6: r=8'h4b; 8'hc7: r=8'h60;
      8'hc8: r=8'h7e; 8'hc9: r=8'h8a; 8'hca: r=8'h76; 8'hcb: r=8'heb;
      8'hcc: r=8'h03; 8'hcd: r=8'hdb; 8'hce: r=8'h29; 8'hcf: r=8'hfa;
      8'hd0: r=8'h57; 8'hd1: r=8'ha1; 8'hd2: r=8'h5b; 8'hd3: r=8'h4f;
      8'hd4: r=8'hd5; 8'hd5: r=8'h70; 8'hd6: r=8'haf; 8'hd7: r=8'hda;
      8'hd8: r=8'hdc; 8'hd9: r=8'hd0; 8'hda: r=8'h08; 8'hdb: r=8'ha4;
      8'hdc: r=8'hdd; 8'hdd: r=8'h0e; 8'hde: r=8'hbc; 8'hdf: r=8'h86;
      8'he0: r=8'h37; 8'he1: r=8'h9d; 8'he2: r=8'hea; 8'he3: r=8'hab;
      8'he4: r=8'h71; 8'he5: r=8'h42; 8'he6: r=8'h9b; 8'he7: r=8'hfc;
      8'he8: r=8'hd8; 8'he9: r=8'hd3; 8'hea: r=8'h2e; 8'heb: r=8'hb0;
      8'hec: r=8'h68; 8'hed: r=8'hce; 8'hee: r=8'hca; 8'hef: r=8'h87;
      8'hf0: r=8'h5e; 8'hf1: r=8'h3e; 8'hf2: r=8'hde; 8'hf3: r=8'h22;
      8'hf4: r=8'h51; 8'hf5: r=8'h40; 8'hf6: r=8'h17; 8'hf7: r=8'h48;
      8'hf8: r=8'h9e; 8'hf9: r=8'h15; 8'hfa: r=8'h0f; 8'hfb: r=8'h73;
      8'hfc: r=8'h06; 8'hfd: r=8'hd2; 8'hfe: r=8'h6a; 8'hff: r=8'h78;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // swap pairs, substitute, chained xor mix
  function automatic block_t fwd_round(input block_t w);
    byte_t b0, b1, b2, b3;
    b0 = fwd_box(w[15:8]);
    b1 = fwd_box(w[7:0]);
    b2 = fwd_box(w[31:24]);
    b3 = fwd_box(w[23:16]);
    b0 = b0 ^ b1 ^ b2;
    b1 = b1 ^ b2 ^ b3;
    b2 = b2 ^ b3 ^ b0;
    b3 = b3 ^ b0 ^ b1;
    return {b3, b2, b1, b0};
  endfunction

  // unmix in reverse order, inverse substitute, swap pairs
  function automatic block_t inv_round(input block_t w);
    byte_t b0, b1, b2, b3;
    b0 = w[7:0];
    b1 = w[15:8];
    b2 = w[23:16];
    b3 = w[31:24];
    b3 = b3 ^ b0 ^ b1;
    b2 = b2 ^ b3 ^ b0;
    b1 = b1 ^ b2 ^ b3;
    b0 = b0 ^ b1 ^ b2;
    return {inv_box(b2), inv_box(b3), inv_box(b0), inv_box(b1)};
  endfunction

endpackage

// ----- sv/sbo_word_if.sv -----
// ----------------------------------------------------------------------------
// sbo_word_if: valid/ready channel carrying one 32-bit block
// ----------------------------------------------------------------------------
interface sbo_word_if;
  logic              valid;
  logic              ready;
  sbo_pkg::block_t   block;

  modport source (output valid, output block, input ready);
  modport sink   (input valid, input block, output ready);
endinterface

// ----- sv/sbox_block_obfuscator_unit.sv -----
// ----------------------------------------------------------------------------
// sbox_block_obfuscator_unit: keyless 4-byte block obfuscation pipeline
// Eight-round substitute/mix transform, forward or inverse per mode.
// ----------------------------------------------------------------------------
// One word in, one word out. Each round is one register stage, and a new
// word may enter every cycle while the pipe is not stalled. The last stage
// doubles as the output register; the pipe stalls as a whole when the output
// word is not taken, and in_if.ready stays high whenever the last stage is
// empty or being drained. The mode register is sampled with each word as it
// enters and travels with it.
module sbox_block_obfuscator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  sbo_word_if.sink   in_if,
  sbo_word_if.source out_if
);
  import sbo_pkg::*;

  logic   mode_q;
  logic   adv;
  logic   vld [Rounds+1];
  logic   mde [Rounds+1];
  block_t blk [Rounds+1];

  // mode register, reset to forward transform
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // global advance: last stage empty or its word taken
  assign adv         = !vld[Rounds] || out_if.ready;
  assign in_if.ready = adv;

  assign vld[0] = in_if.valid;
  assign mde[0] = mode_q;
  assign blk[0] = in_if.block;

  for (genvar g = 0; g < Rounds; g++) begin : g_round
    sbo_round_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[g]),
      .mode_i  (mde[g]),
      .block_i (blk[g]),
      .adv_i   (adv),
      .valid_o (vld[g+1]),
      .mode_o  (mde[g+1]),
      .block_o (blk[g+1])
    );
  end

  assign out_if.valid = vld[Rounds];
  assign out_if.block = blk[Rounds];
endmodule

// ----- sv/sbo_round_stage.sv -----
// ----------------------------------------------------------------------------
// sbo_round_stage: one pipeline stage doing one round
// Holds a word, its mode and a valid bit; advances when downstream frees.
// ----------------------------------------------------------------------------
module sbo_round_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic            mode_i,
  input  sbo_pkg::block_t block_i,
  input  logic            adv_i,
  output logic            valid_o,
  output logic            mode_o,
  output sbo_pkg::block_t block_o
);
  import sbo_pkg::*;

  logic   valid_q, mode_q;
  block_t block_q, block_d;

  assign block_d = mode_i ? fwd_round(block_i) : inv_round(block_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mode_q  <= mode_i;
      block_q <= block_d;
    end
  end

  assign valid_o = valid_q;
  assign mode_o  = mode_q;
  assign block_o = block_q;
endmodule

// ----- tb/sbo_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbo_checker: block transform scoreboard
// Watches both word channels and the mode register. Each accepted input word
// is transformed by an independent model and queued. Each accepted output
// word is compared against the oldest queued value.
// ----------------------------------------------------------------------------
module sbo_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  sbo_pkg::block_t in_block_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  sbo_pkg::block_t out_block_i,
  output int              errors_o,
  output int              pending_o
);
  import sbo_pkg::*;

  localparam int unsigned NumRounds = 8;
  localparam int unsigned MaxReport = 10;

  logic [7:0] sub_tbl [256] = '{
    8'h63,8'h10,8'h6f,8'hcc,8'h70,8'h2b,8'hfc,8'h40,8'hda,8'h5b,8'h31,8'haf,8'h54,8'hc0,8'hdd,8'hfa,
    8'h16,8'hbf,8'h8f,8'h1c,8'h61,8'hf9,8'h77,8'hf6,8'h85,8'h5a,8'h4c,8'h1b,8'h30,8'h27,8'h01,8'h4e,
    8'h9d,8'h71,8'hf3,8'h6d,8'h7a,8'h15,8'h73,8'h60,8'h92,8'hce,8'h37,8'h72,8'h32,8'h35,8'hea,8'ha3,
    8'h84,8'h68,8'h3f,8'h55,8'h0a,8'h0b,8'h24,8'he0,8'h4f,8'h5f,8'h69,8'h67,8'h59,8'h8e,8'hf1,8'h21,
    8'hf5,8'h49,8'he5,8'h4d,8'h80,8'ha6,8'h6a,8'h0f,8'hf7,8'h8c,8'hc1,8'hc6,8'ha0,8'h08,8'hab,8'hd3,
    8'h05,8'hf4,8'h3a,8'h9a,8'h91,8'h0d,8'h4b,8'hd0,8'h6e,8'h79,8'h07,8'hd2,8'h87,8'h11,8'hf0,8'h1a,
    8'hc7,8'hb7,8'h03,8'h39,8'h1d,8'h53,8'h28,8'hbd,8'hec,8'hb8,8'hfe,8'h04,8'h9c,8'h7e,8'h62,8'h06,
    8'hd5,8'he4,8'h7c,8'hfb,8'h74,8'h9f,8'hca,8'h18,8'hff,8'hb2,8'h0c,8'ha1,8'h86,8'h36,8'hc8,8'h9e,
    8'hb0,8'h9b,8'h2e,8'h33,8'h48,8'h09,8'hdf,8'hef,8'h23,8'h3d,8'hc9,8'ha4,8'h56,8'hb5,8'h8b,8'ha2,
    8'h3c,8'h76,8'h82,8'hb3,8'h2a,8'h26,8'h83,8'h98,8'h64,8'h81,8'hbe,8'he6,8'h38,8'he1,8'hf8,8'h58,
    8'hb4,8'hd1,8'hc2,8'h96,8'hdb,8'h93,8'h19,8'hac,8'h52,8'hae,8'h0e,8'he3,8'ha8,8'h51,8'h88,8'hd6,
    8'heb,8'h22,8'h20,8'h8d,8'h1e,8'h2d,8'h3e,8'h43,8'hc3,8'h78,8'h45,8'ha7,8'hde,8'h57,8'h44,8'hbb,
    8'h13,8'ha9,8'h94,8'h14,8'h7f,8'h25,8'h7b,8'h5d,8'h42,8'h34,8'hee,8'h97,8'hb9,8'h29,8'hed,8'h2f,
    8'hd9,8'had,8'hfd,8'he9,8'hc5,8'hd4,8'h99,8'hbc,8'he8,8'hc4,8'hd7,8'hcd,8'hd8,8'hdc,8'hf2,8'h02,
    8'h89,8'h90,8'h50,8'h1f,8'h41,8'hb1,8'hba,8'h8a,8'h95,8'hb6,8'he2,8'hcb,8'ha5,8'h6b,8'h6c,8'h46,
    8'h5c,8'h65,8'h75,8'h2c,8'h5e,8'h3b,8'h7d,8'h12,8'haa,8'h17,8'hcf,8'h47,8'he7,8'h4a,8'h00,8'h66
  };
  logic [7:0] unsub_tbl [256];

  logic   mode_q;
  block_t expected_q[$];
  int     errors;

  // inverse table built from the forward one
  initial begin
    for (int i = 0; i < 256; i++) unsub_tbl[sub_tbl[i]] = i[7:0];
  end

  function automatic block_t transform(input block_t w, input logic enc);
    logic [7:0] b [4];
    logic [7:0] t;
    for (int k = 0; k < 4; k++) b[k] = w[8*k +: 8];
    for (int r = 0; r < NumRounds; r++) begin
      if (enc) begin
        t = b[0]; b[0] = b[1]; b[1] = t;
        t = b[2]; b[2] = b[3]; b[3] = t;
        for (int k = 0; k < 4; k++) b[k] = sub_tbl[b[k]];
        b[0] ^= b[1] ^ b[2];
        b[1] ^= b[2] ^ b[3];
        b[2] ^= b[3] ^ b[0];
        b[3] ^= b[0] ^ b[1];
      end else begin
        b[3] ^= b[0] ^ b[1];
        b[2] ^= b[3] ^ b[0];
        b[1] ^= b[2] ^ b[3];
        b[0] ^= b[1] ^ b[2];
        for (int k = 0; k < 4; k++) b[k] = unsub_tbl[b[k]];
        t = b[0]; b[0] = b[1]; b[1] = t;
        t = b[2]; b[2] = b[3]; b[3] = t;
      end
    end
    return {b[3], b[2], b[1], b[0]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    block_t want;
    if (!rst_ni) begin
      mode_q <= 1'b1;
      errors <= 0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (in_valid_i && in_ready_i) expected_q.push_back(transform(in_block_i, mode_q));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          if (errors < MaxReport) $display("unexpected word %h", out_block_i);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== out_block_i) begin
            if (errors < MaxReport)
              $display("block_out mismatch: expected %h actual %h", want, out_block_i);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  assign errors_o  = errors;
  assign pending_o = expected_q.size();
endmodule

// ----- tb/tb_sbox_block_obfuscator_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sbox_block_obfuscator_unit: top of the block transform testbench
// Drives directed and random words in both modes under several idle and
// stall patterns; a checker beside the DUT predicts and compares.
// ----------------------------------------------------------------------------
module tb_sbox_block_obfuscator_unit;
  import sbo_pkg::*;

  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b1;
  int   errors, pending;
  int   cycles = 0;
  int   send_idle_pct = 0;  // sender idle chance per cycle, percent
  int   recv_stall_pct = 0; // receiver stall chance per cycle, percent

  sbo_word_if in_ch ();
  sbo_word_if out_ch ();

  sbox_block_obfuscator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_ch.sink),
    .out_if     (out_ch.source)
  );

  sbo_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_ch.valid),
    .in_ready_i (in_ch.ready),
    .in_block_i (in_ch.block),
    .out_valid_i(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .out_block_i(out_ch.block),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always #5 clk_i = ~clk_i;

  // receiver: random stalls at the configured rate
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one word: optional idle gaps, then hold valid until accepted
  task automatic send_word(input block_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.block <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // mode write only when the pipe is empty
  task automatic set_mode(input logic enc);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= enc;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random word, biased toward corner bytes now and then
  function automatic block_t rand_word();
    block_t w;
    w = $urandom;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(7))
        0: w[8*k +: 8] = 8'h00;
        1: w[8*k +: 8] = 8'hff;
        default: ;
      endcase
    end
    return w;
  endfunction

  initial begin
    block_t corners [12] = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_00ff,
      32'h0000_ff00, 32'h00ff_0000, 32'hff00_0000, 32'h5555_5555, 32'haaaa_aaaa,
      32'h0102_0304, 32'h0000_0001, 32'h8000_0000, 32'h63fe_63fe};
    in_ch.valid = 1'b0;
    in_ch.block = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corners in reset (encrypt) mode, then decrypt, then back
    foreach (corners[i]) send_word(corners[i]);
    set_mode(1'b0);
    foreach (corners[i]) send_word(corners[i]);
    set_mode(1'b1);

    // random phases: each idle pattern in both modes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      set_mode(ph[0] ^ ph[2]);
      repeat (128) send_word(rand_word());
    end

    in_ch.valid <= 1'b0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
